// ----- hw/rtl/far_pkg.sv -----
`default_nettype none
package far_pkg;
  localparam int unsigned OpW  = 16;
  localparam int unsigned NumW = 33;
  localparam int unsigned DenW = 32;

  typedef struct packed {
    logic            empty;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } job_t;

  typedef struct packed {
    logic            empty;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } res_t;
endpackage
`default_nettype wire

// ----- hw/rtl/far_front.sv -----
`default_nettype none
module far_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [15:0]        ln_i,
  input  wire logic [15:0]        ld_i,
  input  wire logic [15:0]        rn_i,
  input  wire logic [15:0]        rd_i,
  output logic                    job_valid_o,
  input  wire logic               job_ready_i,
  output far_pkg::job_t           job_o
);
  import far_pkg::*;

  // stage 1: products, stage 2: sum; both skid-free, one item in each
  logic            s1_v_q, s2_v_q;
  logic            s1_e_q;
  logic [31:0]     p0_q, p1_q, p2_q;
  job_t            s2_q;
  logic            s1_go, s2_go;

  assign s2_go = !s2_v_q || job_ready_i;
  assign s1_go = !s1_v_q || s2_go;
  assign in_ready_o = s1_go;
  assign job_valid_o = s2_v_q;
  assign job_o = s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_go) s1_v_q <= in_valid_i;
      if (s2_go) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && in_valid_i) begin
      s1_e_q <= ((ln_i == '0) && (ld_i == '0)) || ((rn_i == '0) && (rd_i == '0));
      p0_q   <= ln_i * rd_i;
      p1_q   <= ld_i * rn_i;
      p2_q   <= ld_i * rd_i;
    end
    if (s2_go && s1_v_q) begin
      s2_q.empty <= s1_e_q;
      s2_q.num   <= s1_e_q ? '0 : ({1'b0, p0_q} + {1'b0, p1_q});
      s2_q.den   <= s1_e_q ? '0 : p2_q;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/far_queue.sv -----
`default_nettype none
module far_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire far_pkg::job_t wr_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output far_pkg::job_t      rd_o
);
  import far_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_i;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/far_back.sv -----
`default_nettype none
module far_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  input  wire far_pkg::job_t job_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output far_pkg::res_t      res_o
);
  import far_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StGcd  = 3'd1;
  localparam logic [2:0] StDivN = 3'd2;
  localparam logic [2:0] StDivD = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]      st_q;
  logic            e_q;
  logic [NumW-1:0] n_q, a_q, b_q, g_q, quo_q, rem_q, dvd_q;
  logic [DenW-1:0] d_q;
  logic [5:0]      k_q;
  logic [NumW:0]   trial;
  logic [NumW-1:0] rsh;
  res_t            out_q;
  logic            div_last;

  // binary gcd: subtract-and-shift, stein's method, tracking common twos
  logic [5:0]      tw_q;

  assign job_ready_o = (st_q == StIdle);
  assign res_valid_o = (st_q == StOut);
  assign res_o = out_q;

  assign rsh   = {rem_q[NumW-2:0], dvd_q[NumW-1]};
  assign trial = {1'b0, rsh} - {1'b0, g_q};
  assign div_last = (k_q == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      case (st_q)
        StIdle: if (job_valid_i) begin
          if (job_i.empty || job_i.num == '0 || job_i.den == '0) st_q <= StOut;
          else st_q <= StGcd;
        end
        StGcd:  if (a_q == b_q) st_q <= StDivN;
        StDivN: if (div_last) st_q <= StDivD;
        StDivD: if (div_last) st_q <= StOut;
        StOut:  if (res_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (job_valid_i) begin
        e_q  <= job_i.empty;
        n_q  <= job_i.num;
        d_q  <= job_i.den;
        a_q  <= job_i.num;
        b_q  <= {1'b0, job_i.den};
        tw_q <= '0;
        out_q.empty <= job_i.empty;
        out_q.num   <= job_i.num;
        out_q.den   <= job_i.den;
      end
      StGcd: begin
        if (a_q == b_q) begin
          g_q   <= a_q << tw_q;
          dvd_q <= n_q;
          rem_q <= '0;
          k_q   <= 6'(NumW - 1);
        end else if (!a_q[0] && !b_q[0]) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          tw_q <= tw_q + 6'd1;
        end else if (!a_q[0]) begin
          a_q <= a_q >> 1;
        end else if (!b_q[0]) begin
          b_q <= b_q >> 1;
        end else if (a_q > b_q) begin
          a_q <= (a_q - b_q) >> 1;
        end else begin
          b_q <= (b_q - a_q) >> 1;
        end
      end
      StDivN, StDivD: begin
        if (trial[NumW]) begin
          rem_q <= rsh;
          quo_q <= {quo_q[NumW-2:0], 1'b0};
        end else begin
          rem_q <= trial[NumW-1:0];
          quo_q <= {quo_q[NumW-2:0], 1'b1};
        end
        dvd_q <= dvd_q << 1;
        k_q   <= k_q - 6'd1;
        if (div_last) begin
          if (st_q == StDivN) begin
            out_q.num <= {quo_q[NumW-2:0], ~trial[NumW]};
            dvd_q <= {1'b0, d_q};
            rem_q <= '0;
            k_q   <= 6'(NumW - 1);
          end else begin
            out_q.den <= DenW'({quo_q[NumW-2:0], ~trial[NumW]});
          end
        end
      end
      default: begin
        out_q.empty <= e_q;
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/fraction_add_reduce.sv -----
`default_nettype none
// channel  dir  handshake              payload
// s_axis   in   s_axis_tvalid/tready   tdata: 4 x 16-bit operands
// m_axis   out  m_axis_tvalid/tready   tdata: num, den; tuser: empty
// one item in the back end at a time: the gcd steps, then a divide of the numerator and one of the denominator
// binary gcd loop and the shared restoring divider set the rate
// empty sums and sums with a zero numerator or denominator skip the gcd and divide
// a two-entry queue parts the product front end from the back end
// reset clears the valid flags, queue pointers and count, and the back-end state; payload registers are not reset
module fraction_add_reduce (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // left_numerator, left_denominator, right_numerator, right_denominator
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // sum_numerator [32:0], sum_denominator [64:33], zero fill
  output logic [71:0]      m_axis_tdata,
  // result_empty
  output logic             m_axis_tuser
);
  import far_pkg::*;

  job_t fj, qj;
  res_t r;
  logic fv, fr, qv, qr;

  far_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .ln_i(s_axis_tdata[15:0]), .ld_i(s_axis_tdata[31:16]),
    .rn_i(s_axis_tdata[47:32]), .rd_i(s_axis_tdata[63:48]),
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj)
  );

  far_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fv), .wr_ready_o(fr), .wr_i(fj),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_o(qj)
  );

  far_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(qv), .job_ready_o(qr), .job_i(qj),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(r)
  );

  assign m_axis_tdata = {7'd0, r.den, r.num};
  assign m_axis_tuser = r.empty;
endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import far_pkg::*;

  localparam int unsigned TimeoutCycles = 1500000;

  typedef struct packed {
    logic [OpW-1:0] rd;
    logic [OpW-1:0] rn;
    logic [OpW-1:0] ld;
    logic [OpW-1:0] ln;
  } operands_t;

  typedef struct {
    operands_t ops;
    bit        fixed;
    res_t      sum;
  } vector_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  res_t    sum_queue[$];
  vector_t vectors[$];
  int      errors;
  int      sent;
  int      received;
  int      empty_seen;
  int      cycles;
  bit      hold_off;

  fraction_add_reduce u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic res_t reduced_sum(operands_t o);
    res_t           r;
    logic [63:0]    num;
    logic [63:0]    den;
    logic [63:0]    a;
    logic [63:0]    b;
    logic [63:0]    t;
    r = '0;
    if ((o.ln == 0 && o.ld == 0) || (o.rn == 0 && o.rd == 0)) begin
      r.empty = 1'b1;
      return r;
    end
    num = 64'(o.ln) * 64'(o.rd) + 64'(o.ld) * 64'(o.rn);
    den = 64'(o.ld) * 64'(o.rd);
    a = (num < den) ? den : num;
    b = (num < den) ? num : den;
    if (b != 0) begin
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      num = num / a;
      den = den / a;
    end
    r.num = num[NumW-1:0];
    r.den = den[DenW-1:0];
    return r;
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [OpW-1:0] random_operand();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return OpW'($urandom_range(0, 15));
      default: return OpW'($urandom);
    endcase
  endfunction

  task automatic add_row(logic [OpW-1:0] ln, logic [OpW-1:0] ld, logic [OpW-1:0] rn,
                         logic [OpW-1:0] rd, bit fixed, res_t sum);
    vector_t v;
    v.ops   = '{rd: rd, rn: rn, ld: ld, ln: ln};
    v.fixed = fixed;
    v.sum   = sum;
    vectors.push_back(v);
  endtask

  task automatic send_transfer(vector_t v);
    s_axis_tdata  <= v.ops;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sum_queue.push_back(v.fixed ? v.sum : reduced_sum(v.ops));
    sent++;
    @(negedge clk_i);
  endtask

  initial begin
    vector_t     v;
    logic [15:0] ln;
    logic [15:0] ld;
    logic [15:0] rn;
    logic [15:0] rd;
    int          gap;
    errors        = 0;
    sent          = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_row(0, 0, 0, 0, 1, '{empty: 1'b1, num: '0, den: '0});
    add_row(0, 0, 3, 4, 1, '{empty: 1'b1, num: '0, den: '0});
    add_row(5, 7, 0, 0, 1, '{empty: 1'b1, num: '0, den: '0});
    add_row(16'hffff, 16'hffff, 0, 0, 1, '{empty: 1'b1, num: '0, den: '0});
    add_row(5, 0, 3, 0, 1, '{empty: 1'b0, num: '0, den: '0});
    add_row(0, 5, 0, 7, 1, '{empty: 1'b0, num: '0, den: 35});
    add_row(1, 2, 1, 2, 1, '{empty: 1'b0, num: 1, den: 1});
    add_row(1, 0, 1, 1, 1, '{empty: 1'b0, num: 1, den: 0});
    add_row(16'hffff, 1, 16'hffff, 1, 1, '{empty: 1'b0, num: 33'h1fffe, den: 1});
    add_row(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, '{empty: 1'b0, num: 2, den: 1});
    add_row(16'hffff, 0, 16'hffff, 16'hffff, 0, '0);
    add_row(16'hffff, 16'hffff, 16'hffff, 0, 0, '0);
    add_row(16'hffff, 1, 1, 16'hffff, 0, '0);
    add_row(1, 16'hffff, 1, 16'hfffe, 0, '0);
    add_row(0, 16'hffff, 16'hffff, 16'hffff, 0, '0);
    add_row(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 0, '0);
    add_row(3, 7, 11, 13, 0, '0);
    add_row(12, 18, 20, 30, 0, '0);
    add_row(0, 1, 0, 1, 0, '0);
    add_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, '0);

    foreach (vectors[i]) send_transfer(vectors[i]);

    // stall window: keep offering while the output is held off
    wait (hold_off);
    for (int i = 0; i < 12; i++) begin
      v.fixed = 0;
      v.ops   = {random_operand(), random_operand(), random_operand(), random_operand()};
      send_transfer(v);
    end

    for (int i = 0; i < 1880; i++) begin
      gap = gap_length();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      v.fixed = 0;
      ln = random_operand();
      ld = random_operand();
      rn = random_operand();
      rd = random_operand();
      if ($urandom_range(0, 9) == 0) {ln, ld} = '0;
      if ($urandom_range(0, 9) == 0) {rn, rd} = '0;
      v.ops = '{rd: rd, rn: rn, ld: ld, ln: ln};
      send_transfer(v);
    end
    s_axis_tvalid <= 1'b0;

    while (sum_queue.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("%0d operand pairs sent, %0d sums checked, %0d with an empty operand",
             sent, received, empty_seen);
    if (errors == 0 && sum_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int gap;
    hold_off      = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    m_axis_tready <= 1'b1;
    while (sent < 20) @(negedge clk_i);
    m_axis_tready <= 1'b0;
    hold_off      <= 1'b1;
    repeat (1500) @(negedge clk_i);
    forever begin
      gap = gap_length();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      received++;
      if (m_axis_tuser) empty_seen++;
      if (sum_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer num=%0d den=%0d empty=%0b", $time,
                 m_axis_tdata[32:0], m_axis_tdata[64:33], m_axis_tuser);
      end else begin
        want = sum_queue.pop_front();
        if (m_axis_tdata[32:0] !== want.num) begin
          errors++;
          $display("%0t: numerator expected %0d got %0d", $time, want.num,
                   m_axis_tdata[32:0]);
        end
        if (m_axis_tdata[64:33] !== want.den) begin
          errors++;
          $display("%0t: denominator expected %0d got %0d", $time, want.den,
                   m_axis_tdata[64:33]);
        end
        if (m_axis_tuser !== want.empty) begin
          errors++;
          $display("%0t: empty flag expected %0b got %0b", $time, want.empty,
                   m_axis_tuser);
        end
      end
    end
  end

  initial begin
    received   = 0;
    empty_seen = 0;
    cycles     = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == TimeoutCycles) begin
      $display("status: fail");
      $finish;
    end
  end
endmodule
`default_nettype wire
